/* hw/rtl/doc_pkg.sv */
// Package for the door opener controller: door position codes, request kinds,
// configuration register indexes, their reset values and button press thresholds.
// No dependencies; used by door_opener_controller_unit.
`default_nettype none

package doc_pkg;

  // Default width of the elapsed-tick timers.
  localparam int TIMER_BITS_DEFAULT = 16;

  // Width of the configuration data port (widest register).
  localparam int CFG_W = 16;

  // Door position, held one-hot inside the controller.
  typedef enum logic [6:0] {
    POS_STARTUP   = 7'b0000001,
    POS_OPEN      = 7'b0000010,
    POS_CLOSED    = 7'b0000100,
    POS_OPENING   = 7'b0001000,
    POS_CLOSING   = 7'b0010000,
    POS_OPEN_REQ  = 7'b0100000,
    POS_CLOSE_REQ = 7'b1000000
  } door_pos_t;

  // Door position codes as they appear on the result.
  localparam logic [2:0] CODE_STARTUP   = 3'd0;
  localparam logic [2:0] CODE_OPEN      = 3'd1;
  localparam logic [2:0] CODE_CLOSED    = 3'd2;
  localparam logic [2:0] CODE_OPENING   = 3'd3;
  localparam logic [2:0] CODE_CLOSING   = 3'd4;
  localparam logic [2:0] CODE_OPEN_REQ  = 3'd5;
  localparam logic [2:0] CODE_CLOSE_REQ = 3'd6;

  // Request kinds.
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_SWITCH = 2'd1;
  localparam logic [1:0] REQ_REMOTE = 2'd2;
  localparam logic [1:0] REQ_BUTTON = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_IDLE_OFF        = 3'd0;
  localparam logic [2:0] CFG_FLASH_ON        = 3'd1;
  localparam logic [2:0] CFG_MOVING_OFF      = 3'd2;
  localparam logic [2:0] CFG_REQUEST_OFF     = 3'd3;
  localparam logic [2:0] CFG_REQUEST_ON      = 3'd4;
  localparam logic [2:0] CFG_REQUEST_TIMEOUT = 3'd5;
  localparam logic [2:0] CFG_RETRY_LIMIT     = 3'd6;
  localparam logic [2:0] CFG_ERROR_HOLD      = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [15:0] IDLE_OFF_RESET        = 16'd2000;
  localparam logic [15:0] FLASH_ON_RESET        = 16'd100;
  localparam logic [15:0] MOVING_OFF_RESET      = 16'd300;
  localparam logic [15:0] REQUEST_OFF_RESET     = 16'd200;
  localparam logic [15:0] REQUEST_ON_RESET      = 16'd200;
  localparam logic [15:0] REQUEST_TIMEOUT_RESET = 16'd10000;
  localparam logic [3:0]  RETRY_LIMIT_RESET     = 4'd3;
  localparam logic [15:0] ERROR_HOLD_RESET      = 16'd1000;

  // Button press thresholds in ticks.
  localparam logic [15:0] SHORT_PRESS = 16'd1000;
  localparam logic [15:0] LONG_PRESS  = 16'd5000;

  function automatic logic [2:0] pos_code(door_pos_t pos);
    logic [2:0] code;
    case (pos)
      POS_OPEN:      code = CODE_OPEN;
      POS_CLOSED:    code = CODE_CLOSED;
      POS_OPENING:   code = CODE_OPENING;
      POS_CLOSING:   code = CODE_CLOSING;
      POS_OPEN_REQ:  code = CODE_OPEN_REQ;
      POS_CLOSE_REQ: code = CODE_CLOSE_REQ;
      default:       code = CODE_STARTUP;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/door_opener_controller_unit.sv */
// Door opener controller: position tracking, request retries, lock and LED flashing.
// Depends on doc_pkg.
//
// Latency: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle; the result register is the only stage, and a
// new request is taken whenever that register is empty or being emptied.
// Reset (rst, synchronous): configuration to its defaults, door in startup,
// timers cleared, both LEDs on, no result pending.
`default_nettype none

module door_opener_controller_unit #(
  parameter int TIMER_BITS = doc_pkg::TIMER_BITS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Configuration write port.
  input  wire logic                     cfg_we,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [doc_pkg::CFG_W-1:0] cfg_data,
  // Request channel.
  input  wire logic                     item_valid,
  output logic                          item_stall,
  input  wire logic [1:0]               req_type,
  input  wire logic                     open_switch_closed,
  input  wire logic                     closed_switch_closed,
  input  wire logic                     request_close,
  input  wire logic [15:0]              press_ticks,
  // Result channel.
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output logic [2:0]                    door_state,
  output logic                          door_in_motion,
  output logic                          green_led,
  output logic                          red_led,
  output logic                          relay_pulse,
  output logic                          locked_flag,
  output logic                          state_changed
);

  // Compare width: timers and 16-bit settings are both zero-extended to this.
  localparam int CW = (TIMER_BITS > doc_pkg::CFG_W) ? TIMER_BITS : doc_pkg::CFG_W;

  // Configuration registers.
  logic [15:0] idle_off_ticks;
  logic [15:0] flash_on_ticks;
  logic [15:0] moving_off_ticks;
  logic [15:0] request_off_ticks;
  logic [15:0] request_on_ticks;
  logic [15:0] request_timeout_ticks;
  logic [3:0]  retry_limit;
  logic [15:0] error_hold_ticks;

  // Controller state.
  doc_pkg::door_pos_t    door_pos, door_pos_next;
  logic                  moving, moving_next;
  logic                  lock, lock_next;
  logic [TIMER_BITS-1:0] green_timer, green_timer_next;
  logic [TIMER_BITS-1:0] red_timer, red_timer_next;
  logic [TIMER_BITS-1:0] request_timer, request_timer_next;
  logic [3:0]            retries_left, retries_left_next;
  logic                  green_on, green_on_next;
  logic                  red_on, red_on_next;
  logic [TIMER_BITS-1:0] error_timer, error_timer_next;
  logic                  pulse_next;

  logic accept;
  logic [CW-1:0] green_off_x;

  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_off_ticks        <= doc_pkg::IDLE_OFF_RESET;
      flash_on_ticks        <= doc_pkg::FLASH_ON_RESET;
      moving_off_ticks      <= doc_pkg::MOVING_OFF_RESET;
      request_off_ticks     <= doc_pkg::REQUEST_OFF_RESET;
      request_on_ticks      <= doc_pkg::REQUEST_ON_RESET;
      request_timeout_ticks <= doc_pkg::REQUEST_TIMEOUT_RESET;
      retry_limit           <= doc_pkg::RETRY_LIMIT_RESET;
      error_hold_ticks      <= doc_pkg::ERROR_HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        doc_pkg::CFG_IDLE_OFF:        idle_off_ticks        <= cfg_data;
        doc_pkg::CFG_FLASH_ON:        flash_on_ticks        <= cfg_data;
        doc_pkg::CFG_MOVING_OFF:      moving_off_ticks      <= cfg_data;
        doc_pkg::CFG_REQUEST_OFF:     request_off_ticks     <= cfg_data;
        doc_pkg::CFG_REQUEST_ON:      request_on_ticks      <= cfg_data;
        doc_pkg::CFG_REQUEST_TIMEOUT: request_timeout_ticks <= cfg_data;
        doc_pkg::CFG_RETRY_LIMIT:     retry_limit           <= cfg_data[3:0];
        doc_pkg::CFG_ERROR_HOLD:      error_hold_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Off time of the green flash for resting and moving positions.
  assign green_off_x = (door_pos == doc_pkg::POS_OPENING || door_pos == doc_pkg::POS_CLOSING)
                     ? CW'(moving_off_ticks) : CW'(idle_off_ticks);

  always_comb begin
    door_pos_next      = door_pos;
    moving_next        = moving;
    lock_next          = lock;
    green_timer_next   = green_timer;
    red_timer_next     = red_timer;
    request_timer_next = request_timer;
    retries_left_next  = retries_left;
    green_on_next      = green_on;
    red_on_next        = red_on;
    error_timer_next   = error_timer;
    pulse_next         = 1'b0;

    case (req_type)
      doc_pkg::REQ_TICK: begin
        // Elapsed-tick timers saturate at all ones.
        if (green_timer != '1) green_timer_next = green_timer + 1'b1;
        if (red_timer != '1) red_timer_next = red_timer + 1'b1;
        if (request_timer != '1) request_timer_next = request_timer + 1'b1;

        case (door_pos)
          doc_pkg::POS_OPEN, doc_pkg::POS_CLOSED,
          doc_pkg::POS_OPENING, doc_pkg::POS_CLOSING: begin
            if (CW'(green_timer_next) >= green_off_x && !green_on_next) begin
              green_on_next    = 1'b1;
              green_timer_next = '0;
            end
            if (CW'(green_timer_next) >= CW'(flash_on_ticks) && green_on_next) begin
              green_on_next    = 1'b0;
              green_timer_next = '0;
            end
          end
          doc_pkg::POS_OPEN_REQ, doc_pkg::POS_CLOSE_REQ: begin
            if (CW'(red_timer_next) >= CW'(request_off_ticks) && !red_on_next) begin
              red_on_next    = 1'b1;
              red_timer_next = '0;
            end
            if (CW'(red_timer_next) >= CW'(request_on_ticks) && red_on_next) begin
              red_on_next    = 1'b0;
              red_timer_next = '0;
            end
            // Timeout: pulse the relay again, or give the request up.
            if (CW'(request_timer_next) > CW'(request_timeout_ticks)) begin
              red_on_next        = 1'b0;
              red_timer_next     = '0;
              request_timer_next = '0;
              if (retries_left != '0) retries_left_next = retries_left - 1'b1;
              if (retries_left_next != '0) begin
                pulse_next = 1'b1;
              end else begin
                door_pos_next = (door_pos == doc_pkg::POS_OPEN_REQ)
                              ? doc_pkg::POS_CLOSED : doc_pkg::POS_OPEN;
                moving_next   = 1'b0;
              end
            end
          end
          default: ;
        endcase

        // Red hold after a refused request; it ends only outside a request state.
        if (error_timer != '0) begin
          error_timer_next = error_timer - 1'b1;
          if (error_timer_next == '0 && door_pos_next != doc_pkg::POS_OPEN_REQ &&
              door_pos_next != doc_pkg::POS_CLOSE_REQ)
            red_on_next = 1'b0;
        end
      end

      doc_pkg::REQ_SWITCH: begin
        case (door_pos)
          doc_pkg::POS_STARTUP: begin
            if (open_switch_closed && !closed_switch_closed)
              door_pos_next = doc_pkg::POS_OPEN;
            else if (closed_switch_closed && !open_switch_closed)
              door_pos_next = doc_pkg::POS_CLOSED;
            else
              door_pos_next = doc_pkg::POS_CLOSING;
            moving_next = 1'b0;
          end
          doc_pkg::POS_OPENING, doc_pkg::POS_CLOSING: begin
            // Motion is seen once the switch at the starting end opens.
            if (!moving && ((door_pos == doc_pkg::POS_OPENING) ? !closed_switch_closed
                                                               : !open_switch_closed))
              moving_next = 1'b1;
            if (open_switch_closed && moving_next) begin
              door_pos_next = doc_pkg::POS_OPEN;
              moving_next   = 1'b0;
            end
            if (closed_switch_closed && moving_next) begin
              door_pos_next = doc_pkg::POS_CLOSED;
              moving_next   = 1'b0;
            end
          end
          doc_pkg::POS_OPEN_REQ: begin
            if (!closed_switch_closed && !moving) begin
              moving_next    = 1'b1;
              door_pos_next  = doc_pkg::POS_OPENING;
              red_timer_next = '0;
              red_on_next    = 1'b0;
            end
          end
          doc_pkg::POS_CLOSE_REQ: begin
            if (!open_switch_closed && !moving) begin
              moving_next    = 1'b1;
              door_pos_next  = doc_pkg::POS_CLOSING;
              red_timer_next = '0;
              red_on_next    = 1'b0;
            end
          end
          doc_pkg::POS_CLOSED: begin
            if (!closed_switch_closed && !moving) begin
              moving_next   = 1'b1;
              door_pos_next = doc_pkg::POS_OPENING;
            end
          end
          doc_pkg::POS_OPEN: begin
            if (!open_switch_closed && !moving) begin
              moving_next   = 1'b1;
              door_pos_next = doc_pkg::POS_CLOSING;
            end
          end
          default: ;
        endcase
      end

      doc_pkg::REQ_REMOTE: begin
        if (lock) begin
          red_on_next = 1'b1;
        end else if ((!request_close && door_pos == doc_pkg::POS_CLOSED) ||
                     (request_close && door_pos == doc_pkg::POS_OPEN)) begin
          door_pos_next      = request_close ? doc_pkg::POS_CLOSE_REQ
                                             : doc_pkg::POS_OPEN_REQ;
          red_timer_next     = '0;
          request_timer_next = '0;
          retries_left_next  = retry_limit;
          pulse_next         = 1'b1;
          red_on_next        = 1'b0;
        end else begin
          // Request does not fit the position: hold red on.
          red_on_next      = 1'b1;
          error_timer_next = TIMER_BITS'(error_hold_ticks);
        end
      end

      default: begin
        if (!lock && press_ticks < doc_pkg::SHORT_PRESS) begin
          if (door_pos == doc_pkg::POS_CLOSED || door_pos == doc_pkg::POS_OPEN) begin
            door_pos_next      = (door_pos == doc_pkg::POS_CLOSED)
                               ? doc_pkg::POS_OPEN_REQ : doc_pkg::POS_CLOSE_REQ;
            red_timer_next     = '0;
            request_timer_next = '0;
            retries_left_next  = retry_limit;
          end
          pulse_next  = 1'b1;
          red_on_next = 1'b0;
        end else if (press_ticks > doc_pkg::LONG_PRESS) begin
          lock_next   = ~lock;
          red_on_next = ~lock;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      door_pos      <= doc_pkg::POS_STARTUP;
      moving        <= 1'b0;
      lock          <= 1'b0;
      green_timer   <= '0;
      red_timer     <= '0;
      request_timer <= '0;
      retries_left  <= '0;
      green_on      <= 1'b1;
      red_on        <= 1'b1;
      error_timer   <= '0;
    end else if (accept) begin
      door_pos      <= door_pos_next;
      moving        <= moving_next;
      lock          <= lock_next;
      green_timer   <= green_timer_next;
      red_timer     <= red_timer_next;
      request_timer <= request_timer_next;
      retries_left  <= retries_left_next;
      green_on      <= green_on_next;
      red_on        <= red_on_next;
      error_timer   <= error_timer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      door_state     <= doc_pkg::pos_code(door_pos_next);
      door_in_motion <= moving_next;
      green_led      <= green_on_next;
      red_led        <= red_on_next;
      relay_pulse    <= pulse_next;
      locked_flag    <= lock_next;
      state_changed  <= (door_pos_next != door_pos) || (moving_next != moving);
    end
  end

endmodule

`default_nettype wire
